/* src/tcu_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcu_pkg: teletext cell to utf-8 shared definitions
// Payload types, register indexes, code constants and the national G0
// subset code point table.
// ----------------------------------------------------------------------------
package tcu_pkg;

   // code point width: largest code point is U+25A0
   localparam int CP_W         = 14;
   localparam int NUM_SUBSETS  = 13;
   localparam int NUM_NATIONAL = 13;

   // input transaction
   typedef struct packed {
      logic [6:0] cell_code;
      logic       row_start;
   } req_payload_type;

   // output transaction, one utf-8 byte
   typedef struct packed {
      logic [7:0] utf8_byte;
      logic       last_byte;
   } rsp_payload_type;

   // register indexes
   localparam logic CSR_CHAR_SUBSET = 1'b0;
   localparam logic CSR_BOXED_MODE  = 1'b1;

   // teletext codes
   localparam logic [6:0] CODE_SPACE     = 7'h20;
   localparam logic [6:0] CODE_BLOCK_IN  = 7'h7f;
   localparam logic [6:0] CODE_END_BOX   = 7'h0a;
   localparam logic [6:0] CODE_START_BOX = 7'h0b;
   localparam logic [6:0] CODE_ALPHA_MAX = 7'h07;
   localparam logic [6:0] CODE_MOS_MIN   = 7'h10;
   localparam logic [6:0] CODE_MOS_MAX   = 7'h17;

   localparam logic [CP_W-1:0] CP_SOLID_BLOCK = 14'h25a0;

   // utf-8 framing
   localparam logic [7:0] UTF8_LEAD2 = 8'hc0;
   localparam logic [7:0] UTF8_LEAD3 = 8'he0;
   localparam logic [7:0] UTF8_CONT  = 8'h80;

   // national option positions in the G0 set
   localparam logic [6:0] NAT_POS [NUM_NATIONAL] = '{
      7'h23, 7'h24, 7'h40, 7'h5b, 7'h5c, 7'h5d, 7'h5e,
      7'h5f, 7'h60, 7'h7b, 7'h7c, 7'h7d, 7'h7e
   };

   // code points per subset and national position
   localparam logic [CP_W-1:0] SUBSET_CP [NUM_SUBSETS][NUM_NATIONAL] = '{
      '{14'h00a3, 14'h0024, 14'h0040, 14'h2190, 14'h00bd, 14'h2192, 14'h2191,
        14'h0023, 14'h002d, 14'h00bc, 14'h2016, 14'h00be, 14'h00f7},
      '{14'h0023, 14'h0024, 14'h00a7, 14'h00c4, 14'h00d6, 14'h00dc, 14'h005e,
        14'h005f, 14'h00b0, 14'h00e4, 14'h00f6, 14'h00fc, 14'h00df},
      '{14'h0023, 14'h00a4, 14'h00c9, 14'h00c4, 14'h00d6, 14'h00c5, 14'h00dc,
        14'h005f, 14'h00e9, 14'h00e4, 14'h00f6, 14'h00e5, 14'h00fc},
      '{14'h00a3, 14'h0024, 14'h00e9, 14'h00b0, 14'h00e7, 14'h2192, 14'h2191,
        14'h0023, 14'h00f9, 14'h00e0, 14'h00f2, 14'h00e8, 14'h00ec},
      '{14'h00e9, 14'h00ef, 14'h00e0, 14'h00eb, 14'h00ea, 14'h00f9, 14'h00ee,
        14'h0023, 14'h00e8, 14'h00e2, 14'h00f4, 14'h00fb, 14'h00e7},
      '{14'h00e7, 14'h0024, 14'h00a1, 14'h00e1, 14'h00e9, 14'h00ed, 14'h00f3,
        14'h00fa, 14'h00bf, 14'h00fc, 14'h00f1, 14'h00e8, 14'h00e0},
      '{14'h0023, 14'h016f, 14'h010d, 14'h0165, 14'h017e, 14'h00fd, 14'h00ed,
        14'h0159, 14'h00e9, 14'h00e1, 14'h011b, 14'h00fa, 14'h0161},
      '{14'h0023, 14'h00f5, 14'h0160, 14'h00c4, 14'h00d6, 14'h017d, 14'h00dc,
        14'h00d5, 14'h0161, 14'h00e4, 14'h00f6, 14'h017e, 14'h00fc},
      '{14'h0023, 14'h0144, 14'h0105, 14'h017b, 14'h015a, 14'h0141, 14'h0107,
        14'h00f3, 14'h0119, 14'h017a, 14'h015b, 14'h0142, 14'h017c},
      '{14'h0023, 14'h0024, 14'h0160, 14'h0117, 14'h0119, 14'h017d, 14'h010d,
        14'h016b, 14'h0161, 14'h0105, 14'h0173, 14'h017e, 14'h012f},
      '{14'h0023, 14'h00a4, 14'h021a, 14'h00c2, 14'h0218, 14'h0102, 14'h00ce,
        14'h0131, 14'h021b, 14'h00e2, 14'h0219, 14'h0103, 14'h00ee},
      '{14'h0023, 14'h00cb, 14'h010c, 14'h0106, 14'h017d, 14'h0110, 14'h0160,
        14'h00eb, 14'h010d, 14'h0107, 14'h017e, 14'h0111, 14'h0161},
      '{14'h20ba, 14'h011f, 14'h0130, 14'h015e, 14'h00d6, 14'h00c7, 14'h00dc,
        14'h011e, 14'h0131, 14'h015f, 14'h00f6, 14'h00e7, 14'h00fc}
   };

endpackage

`default_nettype wire

/* src/teletext_cell_to_utf8.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// teletext_cell_to_utf8: level 1 teletext cell to utf-8 byte stream
// Converts one 7-bit cell per transaction into one to three utf-8 bytes.
//
// Channels: req_* takes a cell code and a row start flag; rsp_* returns one
// utf-8 byte per transaction, last_byte marking the final byte of a cell.
// csr_* writes char_subset (index 0) and the boxed mode flag (index 1); it is
// always ready and must only be written while no cell is in flight.
// A taken cell passes the decode stage register (decode and table read) and
// then the byte serializer register before its first byte is offered.
// The output serializer sends one byte per cycle while rsp_ready is high:
// one byte for ascii cells, two for U+0080..U+07FF, three for higher code
// points.
// A new cell is taken while bytes of earlier cells are still waiting.
// Reset: subset English, ordinary page, alphanumeric mode, text visible,
// pipeline empty.
// Receiver stall: bytes hold on rsp_payload, and the decode stage fills and
// then drops req_ready until the serializer drains.
// ----------------------------------------------------------------------------
module teletext_cell_to_utf8
   import tcu_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire req_payload_type req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_payload_type      rsp_payload,
   input  wire logic            csr_valid,
   output logic                 csr_ready,
   input  wire logic            csr_index,
   input  wire logic [3:0]      csr_data
);

   // configuration and row state
   logic [3:0]      subset_ff, subset_in;
   logic            boxed_ff, boxed_in;
   logic            alpha_ff, alpha_in;
   logic            box_vis_ff, box_vis_in;

   // decode stage
   logic            s1_valid_ff, s1_valid_in;
   logic            s1_use_rom_ff, s1_use_rom_in;
   logic [CP_W-1:0] s1_cp_ff, s1_cp_in;
   logic [CP_W-1:0] rom_q_ff, rom_q_in;

   // byte serializer
   logic            s2_valid_ff, s2_valid_in;
   logic [1:0]      s2_remain_ff, s2_remain_in;
   logic [7:0]      s2_byte0_ff, s2_byte0_in;
   logic [7:0]      s2_byte1_ff, s2_byte1_in;
   logic [7:0]      s2_byte2_ff, s2_byte2_in;

   logic            req_fire;
   logic            rsp_fire;
   logic            s2_take;
   logic            s1_move;
   logic [6:0]      code;
   logic            alpha_cur;
   logic            box_cur;
   logic            nat_hit;
   logic [3:0]      nat_idx;
   logic [3:0]      subset_sel;
   logic [CP_W-1:0] cp;

   // handshakes
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign s2_take   = !s2_valid_ff || (rsp_ready && (s2_remain_ff == 2'd1));
   assign s1_move   = s1_valid_ff && s2_take;
   assign req_ready = !s1_valid_ff || s2_take;
   assign csr_ready = 1'b1;

   assign code = req_payload.cell_code;

   // national position search
   always_comb begin
      nat_hit = 1'b0;
      nat_idx = 4'd0;
      for (int k = 0; k < NUM_NATIONAL; k++) begin
         if (code == NAT_POS[k]) begin
            nat_hit = 1'b1;
            nat_idx = 4'(k);
         end
      end
   end

   // unknown subsets fall back to english
   assign subset_sel = (subset_ff < 4'(NUM_SUBSETS)) ? subset_ff : 4'd0;

   // configuration writes
   always_comb begin
      subset_in = subset_ff;
      boxed_in  = boxed_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CHAR_SUBSET: subset_in = csr_data;
            CSR_BOXED_MODE:  boxed_in  = csr_data[0];
            default:         subset_in = subset_ff;
         endcase
      end
   end

   // cell decode, mode update and table read
   always_comb begin
      alpha_cur     = req_payload.row_start ? 1'b1 : alpha_ff;
      box_cur       = req_payload.row_start ? !boxed_ff : box_vis_ff;
      alpha_in      = alpha_ff;
      box_vis_in    = box_vis_ff;
      s1_use_rom_in = s1_use_rom_ff;
      s1_cp_in      = s1_cp_ff;
      rom_q_in      = rom_q_ff;
      if (req_fire) begin
         alpha_in      = alpha_cur;
         box_vis_in    = box_cur;
         s1_use_rom_in = 1'b0;
         s1_cp_in      = {{(CP_W-7){1'b0}}, CODE_SPACE};
         rom_q_in      = SUBSET_CP[subset_sel][nat_idx];
         if (code < CODE_SPACE) begin
            // control code: space, mode changes apply to later cells
            if (code <= CODE_ALPHA_MAX) begin
               alpha_in = 1'b1;
            end else if (code >= CODE_MOS_MIN && code <= CODE_MOS_MAX) begin
               alpha_in = 1'b0;
            end
            if (boxed_ff && code == CODE_END_BOX) begin
               box_vis_in = 1'b0;
            end else if (boxed_ff && code == CODE_START_BOX) begin
               box_vis_in = 1'b1;
            end
         end else if (box_cur && alpha_cur) begin
            if (code == CODE_BLOCK_IN) begin
               s1_cp_in = CP_SOLID_BLOCK;
            end else if (nat_hit) begin
               s1_use_rom_in = 1'b1;
            end else begin
               s1_cp_in = {{(CP_W-7){1'b0}}, code};
            end
         end
      end
   end

   // decode stage occupancy
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   assign cp = s1_use_rom_ff ? rom_q_ff : s1_cp_ff;

   // serializer load and byte shift
   always_comb begin
      s2_valid_in  = s2_valid_ff;
      s2_remain_in = s2_remain_ff;
      s2_byte0_in  = s2_byte0_ff;
      s2_byte1_in  = s2_byte1_ff;
      s2_byte2_in  = s2_byte2_ff;
      if (s1_move) begin
         s2_valid_in = 1'b1;
         s2_byte2_in = 8'h00;
         if (cp[CP_W-1:7] == '0) begin
            s2_remain_in = 2'd1;
            s2_byte0_in  = {1'b0, cp[6:0]};
            s2_byte1_in  = 8'h00;
         end else if (cp[CP_W-1:11] == '0) begin
            s2_remain_in = 2'd2;
            s2_byte0_in  = UTF8_LEAD2 | {3'b000, cp[10:6]};
            s2_byte1_in  = UTF8_CONT | {2'b00, cp[5:0]};
         end else begin
            s2_remain_in = 2'd3;
            s2_byte0_in  = UTF8_LEAD3 | {6'b000000, cp[13:12]};
            s2_byte1_in  = UTF8_CONT | {2'b00, cp[11:6]};
            s2_byte2_in  = UTF8_CONT | {2'b00, cp[5:0]};
         end
      end else if (rsp_fire) begin
         s2_remain_in = s2_remain_ff - 2'd1;
         s2_byte0_in  = s2_byte1_ff;
         s2_byte1_in  = s2_byte2_ff;
         if (s2_remain_ff == 2'd1) begin
            s2_valid_in = 1'b0;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         subset_ff   <= 4'd0;
         boxed_ff    <= 1'b0;
         alpha_ff    <= 1'b1;
         box_vis_ff  <= 1'b1;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         subset_ff   <= subset_in;
         boxed_ff    <= boxed_in;
         alpha_ff    <= alpha_in;
         box_vis_ff  <= box_vis_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_use_rom_ff <= s1_use_rom_in;
      s1_cp_ff      <= s1_cp_in;
      rom_q_ff      <= rom_q_in;
      s2_remain_ff  <= s2_remain_in;
      s2_byte0_ff   <= s2_byte0_in;
      s2_byte1_ff   <= s2_byte1_in;
      s2_byte2_ff   <= s2_byte2_in;
   end

   // output transaction
   assign rsp_valid             = s2_valid_ff;
   assign rsp_payload.utf8_byte = s2_byte0_ff;
   assign rsp_payload.last_byte = (s2_remain_ff == 2'd1);

endmodule

`default_nettype wire

/* tb/tb_teletext_cell_to_utf8.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_teletext_cell_to_utf8: self-checking bench for the cell to utf-8 block
// Runs a short directed table, then random phases with new register
// settings. Each cell is rendered to a code point and utf-8 bytes by a
// predictor of the block's mode and box state, unless a directed row gives
// its bytes; the bytes returned are compared in order against that.
// ----------------------------------------------------------------------------
module tb_teletext_cell_to_utf8;
   import tcu_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 10;
   localparam int TABLE_ROWS   = 27;
   localparam int PHASES       = 8;
   localparam int PHASE_CELLS  = 25;

   // national option positions and the glyph each subset puts there
   localparam logic [6:0] NAT_CODES [13] = '{
      7'h23, 7'h24, 7'h40, 7'h5b, 7'h5c, 7'h5d, 7'h5e,
      7'h5f, 7'h60, 7'h7b, 7'h7c, 7'h7d, 7'h7e
   };

   localparam logic [15:0] NAT_GLYPHS [13][13] = '{
      '{16'h00a3, 16'h0024, 16'h0040, 16'h2190, 16'h00bd, 16'h2192, 16'h2191,
        16'h0023, 16'h002d, 16'h00bc, 16'h2016, 16'h00be, 16'h00f7},
      '{16'h0023, 16'h0024, 16'h00a7, 16'h00c4, 16'h00d6, 16'h00dc, 16'h005e,
        16'h005f, 16'h00b0, 16'h00e4, 16'h00f6, 16'h00fc, 16'h00df},
      '{16'h0023, 16'h00a4, 16'h00c9, 16'h00c4, 16'h00d6, 16'h00c5, 16'h00dc,
        16'h005f, 16'h00e9, 16'h00e4, 16'h00f6, 16'h00e5, 16'h00fc},
      '{16'h00a3, 16'h0024, 16'h00e9, 16'h00b0, 16'h00e7, 16'h2192, 16'h2191,
        16'h0023, 16'h00f9, 16'h00e0, 16'h00f2, 16'h00e8, 16'h00ec},
      '{16'h00e9, 16'h00ef, 16'h00e0, 16'h00eb, 16'h00ea, 16'h00f9, 16'h00ee,
        16'h0023, 16'h00e8, 16'h00e2, 16'h00f4, 16'h00fb, 16'h00e7},
      '{16'h00e7, 16'h0024, 16'h00a1, 16'h00e1, 16'h00e9, 16'h00ed, 16'h00f3,
        16'h00fa, 16'h00bf, 16'h00fc, 16'h00f1, 16'h00e8, 16'h00e0},
      '{16'h0023, 16'h016f, 16'h010d, 16'h0165, 16'h017e, 16'h00fd, 16'h00ed,
        16'h0159, 16'h00e9, 16'h00e1, 16'h011b, 16'h00fa, 16'h0161},
      '{16'h0023, 16'h00f5, 16'h0160, 16'h00c4, 16'h00d6, 16'h017d, 16'h00dc,
        16'h00d5, 16'h0161, 16'h00e4, 16'h00f6, 16'h017e, 16'h00fc},
      '{16'h0023, 16'h0144, 16'h0105, 16'h017b, 16'h015a, 16'h0141, 16'h0107,
        16'h00f3, 16'h0119, 16'h017a, 16'h015b, 16'h0142, 16'h017c},
      '{16'h0023, 16'h0024, 16'h0160, 16'h0117, 16'h0119, 16'h017d, 16'h010d,
        16'h016b, 16'h0161, 16'h0105, 16'h0173, 16'h017e, 16'h012f},
      '{16'h0023, 16'h00a4, 16'h021a, 16'h00c2, 16'h0218, 16'h0102, 16'h00ce,
        16'h0131, 16'h021b, 16'h00e2, 16'h0219, 16'h0103, 16'h00ee},
      '{16'h0023, 16'h00cb, 16'h010c, 16'h0106, 16'h017d, 16'h0110, 16'h0160,
        16'h00eb, 16'h010d, 16'h0107, 16'h017e, 16'h0111, 16'h0161},
      '{16'h20ba, 16'h011f, 16'h0130, 16'h015e, 16'h00d6, 16'h00c7, 16'h00dc,
        16'h011e, 16'h0131, 16'h015f, 16'h00f6, 16'h00e7, 16'h00fc}
   };

   localparam logic [15:0] GLYPH_SOLID_BLOCK = 16'h25a0;

   typedef enum logic {ROW_CELL, ROW_REG} row_kind_type;

   // bytes known up front for a directed cell; count 0 means predict them
   typedef struct packed {
      logic [1:0]  count;
      logic [23:0] bytes;
   } known_bytes_type;

   typedef struct packed {
      row_kind_type    kind;
      logic            reg_index;
      logic [3:0]      reg_value;
      req_payload_type cell_req;
      known_bytes_type known;
   } table_row_type;

   logic            clock       = 1'b0;
   logic            reset       = 1'b1;
   logic            req_valid   = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready   = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_valid   = 1'b0;
   logic            csr_ready;
   logic            csr_index   = 1'b0;
   logic [3:0]      csr_data    = 4'd0;

   // predictor state and register copies
   logic       in_alpha   = 1'b1;
   logic       box_shown  = 1'b1;
   logic [3:0] cfg_subset = 4'd0;
   logic       cfg_boxed  = 1'b0;

   rsp_payload_type pending_bytes [$];
   known_bytes_type known_bytes_q [$];
   int unsigned     mismatches    = 0;
   int unsigned     req_idle_pct  = 24;
   int unsigned     rsp_idle_pct  = 24;
   table_row_type   directed_table [TABLE_ROWS];

   teletext_cell_to_utf8 u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always #6 clock = ~clock;

   // receiver stalls at random
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // row start and control codes update the mode bits, then the glyph is chosen
   function automatic logic [15:0] next_glyph(input req_payload_type c);
      logic [3:0]  s;
      logic [15:0] cp;
      s = (cfg_subset < NUM_SUBSETS) ? cfg_subset : 4'd0;
      if (c.row_start) begin
         in_alpha  = 1'b1;
         box_shown = !cfg_boxed;
      end
      if (c.cell_code < CODE_SPACE) begin
         if (c.cell_code <= CODE_ALPHA_MAX) begin
            in_alpha = 1'b1;
         end else if (c.cell_code >= CODE_MOS_MIN && c.cell_code <= CODE_MOS_MAX) begin
            in_alpha = 1'b0;
         end
         if (cfg_boxed && c.cell_code == CODE_END_BOX) begin
            box_shown = 1'b0;
         end else if (cfg_boxed && c.cell_code == CODE_START_BOX) begin
            box_shown = 1'b1;
         end
         cp = {9'd0, CODE_SPACE};
      end else if (!box_shown || !in_alpha) begin
         cp = {9'd0, CODE_SPACE};
      end else if (c.cell_code == CODE_BLOCK_IN) begin
         cp = GLYPH_SOLID_BLOCK;
      end else begin
         cp = {9'd0, c.cell_code};
         for (int k = 0; k < 13; k++) begin
            if (c.cell_code == NAT_CODES[k]) cp = NAT_GLYPHS[s][k];
         end
      end
      return cp;
   endfunction

   // utf-8 encoding of one code point, one entry per byte
   task automatic push_utf8(input logic [15:0] cp);
      if (cp <= 16'h007f) begin
         pending_bytes.push_back({cp[7:0], 1'b1});
      end else if (cp <= 16'h07ff) begin
         pending_bytes.push_back({3'b110, cp[10:6], 1'b0});
         pending_bytes.push_back({2'b10, cp[5:0], 1'b1});
      end else begin
         pending_bytes.push_back({4'b1110, cp[15:12], 1'b0});
         pending_bytes.push_back({2'b10, cp[11:6], 1'b0});
         pending_bytes.push_back({2'b10, cp[5:0], 1'b1});
      end
   endtask

   task automatic report_mismatch(input string what, input rsp_payload_type want,
                                  input rsp_payload_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch (%0s) at %0t: expected byte %02h last %0b, got byte %02h last %0b",
                  what, $realtime, want.utf8_byte, want.last_byte, got.utf8_byte,
                  got.last_byte);
      end
   endtask

   // track accepted transactions on all three channels
   always @(posedge clock) begin : scoreboard
      known_bytes_type known;
      logic [15:0]     cp;
      rsp_payload_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_CHAR_SUBSET) cfg_subset = csr_data;
            else cfg_boxed = csr_data[0];
         end
         if (req_valid && req_ready) begin
            known = known_bytes_q.pop_front();
            cp = next_glyph(req_payload);
            if (known.count == 2'd0) begin
               push_utf8(cp);
            end else begin
               for (int j = 0; j < known.count; j++) begin
                  pending_bytes.push_back({known.bytes[23 - 8*j -: 8], j == known.count - 1});
               end
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_bytes.size() == 0) begin
               report_mismatch("no byte pending", '0, rsp_payload);
            end else begin
               want = pending_bytes.pop_front();
               if (rsp_payload.utf8_byte !== want.utf8_byte) begin
                  report_mismatch("utf8_byte", want, rsp_payload);
               end else if (rsp_payload.last_byte !== want.last_byte) begin
                  report_mismatch("last_byte", want, rsp_payload);
               end
            end
         end
      end
   end

   // end the run if the block stops moving
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("end of test: mismatches");
      $finish;
   end

   function automatic table_row_type cell_row(input logic [6:0] code, input logic rs);
      return {ROW_CELL, 1'b0, 4'd0, code, rs, 2'd0, 24'd0};
   endfunction

   function automatic table_row_type known_row(input logic [6:0] code, input logic rs,
                                               input logic [1:0] n, input logic [23:0] b);
      return {ROW_CELL, 1'b0, 4'd0, code, rs, n, b};
   endfunction

   function automatic table_row_type reg_row(input logic idx, input logic [3:0] val);
      return {ROW_REG, idx, val, 7'd0, 1'b0, 2'd0, 24'd0};
   endfunction

   function automatic req_payload_type random_cell();
      req_payload_type c;
      int unsigned     pick;
      pick        = $urandom_range(99);
      c.row_start = ($urandom_range(99) < 8);
      if (pick < 12) c.cell_code = 7'($urandom_range(31));
      else if (pick < 16) c.cell_code = CODE_START_BOX;
      else if (pick < 20) c.cell_code = CODE_END_BOX;
      else if (pick < 45) c.cell_code = NAT_CODES[$urandom_range(12)];
      else if (pick < 50) c.cell_code = CODE_BLOCK_IN;
      else c.cell_code = 7'($urandom_range(127));
      return c;
   endfunction

   // one cell transaction, with random idle cycles in front
   task automatic send_cell(input req_payload_type item);
      csr_valid <= 1'b0;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // register write once every pending byte has come back
   task automatic write_reg(input logic idx, input logic [3:0] val);
      req_valid <= 1'b0;
      while (pending_bytes.size() != 0) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin : stimulus
      directed_table = '{
         // after reset: english, ordinary page
         known_row(7'h41, 1'b1, 2'd1, 24'h410000),
         known_row(CODE_BLOCK_IN, 1'b0, 2'd3, 24'he296a0),
         known_row(7'h23, 1'b0, 2'd2, 24'hc2a300),
         known_row(7'h5b, 1'b0, 2'd3, 24'he28690),
         known_row(7'h00, 1'b0, 2'd1, 24'h200000),
         known_row(CODE_MOS_MAX, 1'b0, 2'd1, 24'h200000),
         cell_row(7'h41, 1'b0),
         cell_row(CODE_ALPHA_MAX, 1'b0),
         cell_row(7'h7e, 1'b0),
         cell_row(CODE_END_BOX, 1'b0),
         cell_row(7'h40, 1'b0),
         // boxed page, subset past the table end
         reg_row(CSR_BOXED_MODE, 4'd1),
         reg_row(CSR_CHAR_SUBSET, 4'd15),
         cell_row(CODE_SPACE, 1'b1),
         cell_row(7'h41, 1'b0),
         cell_row(CODE_START_BOX, 1'b0),
         cell_row(7'h24, 1'b0),
         cell_row(7'h5c, 1'b0),
         cell_row(CODE_END_BOX, 1'b0),
         cell_row(7'h5c, 1'b0),
         // page type changed mid-row: box stays hidden until the next row
         reg_row(CSR_CHAR_SUBSET, 4'd12),
         reg_row(CSR_BOXED_MODE, 4'd0),
         cell_row(7'h23, 1'b0),
         cell_row(7'h23, 1'b1),
         cell_row(CODE_MOS_MIN, 1'b0),
         cell_row(CODE_BLOCK_IN, 1'b0),
         cell_row(7'h60, 1'b1)
      };

      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      for (int i = 0; i < TABLE_ROWS; i++) begin
         if (directed_table[i].kind == ROW_REG) begin
            write_reg(directed_table[i].reg_index, directed_table[i].reg_value);
         end else begin
            known_bytes_q.push_back(directed_table[i].known);
            send_cell(directed_table[i].cell_req);
         end
      end

      // random phases, new settings each time, one phase with no idling
      for (int ph = 0; ph < PHASES; ph++) begin
         write_reg(CSR_CHAR_SUBSET, 4'($urandom_range(15)));
         write_reg(CSR_BOXED_MODE, 4'($urandom_range(1)));
         req_idle_pct = (ph == 4) ? 0 : 24;
         rsp_idle_pct = (ph == 4) ? 0 : 24;
         for (int i = 0; i < PHASE_CELLS; i++) begin
            known_bytes_q.push_back('0);
            send_cell(random_cell());
         end
      end

      // drain, then allow for any stray bytes
      req_valid <= 1'b0;
      while (pending_bytes.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatches == 0 && pending_bytes.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

`default_nettype wire
